// File: hdl/lswg_pkg.sv
// Package for the 9-bit serial LCD window/glyph writer.
// Holds action codes, command bytes, register indexes and the queue entry types.
// Depends on nothing; used by the front end, queue, back end, top level and testbench.
`default_nettype none

package lswg_pkg;

  // Input action codes
  localparam logic [2:0] ActSetWindow = 3'd0;
  localparam logic [2:0] ActPixel     = 3'd1;
  localparam logic [2:0] ActGlyphRow  = 3'd2;
  localparam logic [2:0] ActRawCmd    = 3'd3;
  localparam logic [2:0] ActRawData   = 3'd4;

  // Display command bytes
  localparam logic [7:0] CmdColumnAddr = 8'h2A;
  localparam logic [7:0] CmdRowAddr    = 8'h2B;
  localparam logic [7:0] CmdMemWrite   = 8'h2C;

  // Register-select bit of a serial word
  localparam logic RsCommand = 1'b0;
  localparam logic RsData    = 1'b1;

  // Configuration register indexes; indexes 2 and 3 select nothing
  localparam int                  CfgIndexW    = 2;
  localparam int                  ColorW       = 16;
  localparam logic [CfgIndexW-1:0] CfgTextColor = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgBackColor = 2'd1;
  localparam logic [15:0]         TextColorRst = 16'h0000;
  localparam logic [15:0]         BackColorRst = 16'hFFFF;

  // Word counter: up to 32 words per item
  localparam int CntW = 5;
  localparam logic [CntW-1:0] WinLastCnt   = 5'd10;
  localparam logic [CntW-1:0] PixLastCnt   = 5'd1;
  localparam logic [CntW-1:0] GlyphLastCnt = 5'd31;

  localparam int QueueDepth = 2;
  localparam int OpsW       = 64;

  typedef enum logic [2:0] {
    KIND_WINDOW,
    KIND_PIXEL,
    KIND_GLYPH,
    KIND_CMD,
    KIND_DATA
  } kind_t;

  // Operands: window {x_start, x_end, y_start, y_end}; others in the low bits
  typedef struct packed {
    kind_t           kind;
    logic [OpsW-1:0] ops;
  } entry_t;

  typedef struct packed {
    logic [ColorW-1:0] text;
    logic [ColorW-1:0] back;
  } colors_t;

endpackage

`default_nettype wire

// File: hdl/lswg_if.sv
// Channel interfaces of the serial LCD writer: drawing items in, serial words out.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface lswg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] x_start;
  logic [15:0] y_start;
  logic [15:0] win_width;
  logic [15:0] win_height;
  logic [15:0] pixel_value;
  logic [15:0] glyph_bits;
  logic [7:0]  byte_value;

  modport source (output valid, action, x_start, y_start, win_width, win_height,
                  pixel_value, glyph_bits, byte_value, input ready);
  modport sink (input valid, action, x_start, y_start, win_width, win_height,
                pixel_value, glyph_bits, byte_value, output ready);
endinterface

interface lswg_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] serial_word;
  logic       select_release;
  logic       last_word;

  modport source (output valid, serial_word, select_release, last_word, input ready);
  modport sink (input valid, serial_word, select_release, last_word, output ready);
endinterface

`default_nettype wire

// File: hdl/lswg_front.sv
// Front end: accepts drawing items, classifies them and computes window ends.
// Depends on lswg_pkg and lswg_in_if; feeds lswg_queue.
`default_nettype none

module lswg_front (
  lswg_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             push,
  output lswg_pkg::entry_t push_entry
);

  logic        known;
  logic [15:0] x_end;
  logic [15:0] y_end;

  // end = start + size - 1, wrapping at 16 bits
  assign x_end = 16'(in_ch.x_start + in_ch.win_width - 16'd1);
  assign y_end = 16'(in_ch.y_start + in_ch.win_height - 16'd1);

  // Unused action codes are taken and dropped
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full && known;

  always_comb begin
    known           = 1'b1;
    push_entry.kind = lswg_pkg::KIND_CMD;
    push_entry.ops  = {56'd0, in_ch.byte_value};
    unique case (in_ch.action)
      lswg_pkg::ActSetWindow: begin
        push_entry.kind = lswg_pkg::KIND_WINDOW;
        push_entry.ops  = {in_ch.x_start, x_end, in_ch.y_start, y_end};
      end
      lswg_pkg::ActPixel: begin
        push_entry.kind = lswg_pkg::KIND_PIXEL;
        push_entry.ops  = {48'd0, in_ch.pixel_value};
      end
      lswg_pkg::ActGlyphRow: begin
        push_entry.kind = lswg_pkg::KIND_GLYPH;
        push_entry.ops  = {48'd0, in_ch.glyph_bits};
      end
      lswg_pkg::ActRawCmd: begin
        push_entry.kind = lswg_pkg::KIND_CMD;
      end
      lswg_pkg::ActRawData: begin
        push_entry.kind = lswg_pkg::KIND_DATA;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/lswg_queue.sv
// Short FIFO of classified items between front end and word sequencer.
// Depends on lswg_pkg.
`default_nettype none

module lswg_queue #(
  parameter int Depth = lswg_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lswg_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output lswg_pkg::entry_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  lswg_pkg::entry_t  slots [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CountW'(Depth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CountW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CountW'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/lswg_back.sv
// Back end: walks one queued item word by word into a registered output stage.
// Depends on lswg_pkg and lswg_out_if; pulls from lswg_queue.
`default_nettype none

module lswg_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  lswg_pkg::entry_t  q_head,
  output logic              q_pop,
  input  lswg_pkg::colors_t colors,
  lswg_out_if.source        out_ch
);

  lswg_pkg::entry_t          cur;
  logic                      active;
  logic [lswg_pkg::CntW-1:0] cnt;
  logic                      out_valid;
  logic [8:0]                out_word;
  logic                      out_release;
  logic                      out_last;

  logic        advance;
  logic        load;
  logic [8:0]  word;
  logic        release_bit;
  logic        is_last;
  logic [15:0] pix;

  assign advance = active && (!out_valid || out_ch.ready);
  assign load    = q_not_empty && (!active || (advance && is_last));
  assign q_pop   = load;

  always_comb begin
    word        = {lswg_pkg::RsData, 8'h00};
    release_bit = 1'b1;
    is_last     = 1'b1;
    pix         = cur.ops[15:0];
    unique case (cur.kind)
      lswg_pkg::KIND_WINDOW: begin
        is_last = (cnt == lswg_pkg::WinLastCnt);
        case (cnt)
          5'd0:    word = {lswg_pkg::RsCommand, lswg_pkg::CmdColumnAddr};
          5'd1:    word = {lswg_pkg::RsData, cur.ops[63:56]};
          5'd2:    word = {lswg_pkg::RsData, cur.ops[55:48]};
          5'd3:    word = {lswg_pkg::RsData, cur.ops[47:40]};
          5'd4:    word = {lswg_pkg::RsData, cur.ops[39:32]};
          5'd5:    word = {lswg_pkg::RsCommand, lswg_pkg::CmdRowAddr};
          5'd6:    word = {lswg_pkg::RsData, cur.ops[31:24]};
          5'd7:    word = {lswg_pkg::RsData, cur.ops[23:16]};
          5'd8:    word = {lswg_pkg::RsData, cur.ops[15:8]};
          5'd9:    word = {lswg_pkg::RsData, cur.ops[7:0]};
          default: word = {lswg_pkg::RsCommand, lswg_pkg::CmdMemWrite};
        endcase
      end
      lswg_pkg::KIND_PIXEL, lswg_pkg::KIND_GLYPH: begin
        if (cur.kind == lswg_pkg::KIND_GLYPH) begin
          // pixel index is cnt[4:1]; bit 0 of the row goes first
          pix     = cur.ops[{2'b00, cnt[4:1]}] ? colors.text : colors.back;
          is_last = (cnt == lswg_pkg::GlyphLastCnt);
        end else begin
          is_last = (cnt == lswg_pkg::PixLastCnt);
        end
        word        = {lswg_pkg::RsData, cnt[0] ? pix[7:0] : pix[15:8]};
        release_bit = cnt[0];
      end
      lswg_pkg::KIND_CMD: begin
        word = {lswg_pkg::RsCommand, cur.ops[7:0]};
      end
      lswg_pkg::KIND_DATA: begin
        word = {lswg_pkg::RsData, cur.ops[7:0]};
      end
      default: begin
        word = {lswg_pkg::RsData, cur.ops[7:0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (advance) begin
        active <= !is_last;
        cnt    <= lswg_pkg::CntW'(cnt + 1'b1);
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_head;
    end
    if (advance) begin
      out_word    <= word;
      out_release <= release_bit;
      out_last    <= is_last;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.serial_word    = out_word;
  assign out_ch.select_release = out_release;
  assign out_ch.last_word      = out_last;

endmodule

`default_nettype wire

// File: hdl/lcd_serial_window_glyph_writer_unit.sv
// Top level of the 9-bit serial LCD window/glyph writer.
// Depends on lswg_pkg, lswg_if, lswg_front, lswg_queue and lswg_back.
//
//   channel  dir  handshake        carries
//   in_ch    in   valid/ready      action and drawing operands, one item
//   out_ch   out  valid/ready      serial_word, select_release, last_word
//   cfg      in   cfg_we           cfg_index, cfg_data (text/back color)
//
// One serial word per cycle from the back-end word sequencer while out_ch is
// ready: set window 11 words, pixel 2, glyph row 32, raw command/data 1;
// unused actions are accepted and emit nothing. An item can be accepted every
// cycle while the queue has room; sustained rate is set by the sequencer.
// Reset (sync, active high) empties queue and output stage and restores
// colors. A stalled out_ch holds its word; the queue keeps taking items until full.
`default_nettype none

module lcd_serial_window_glyph_writer_unit #(
  parameter int QueueDepth = lswg_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst,
  lswg_in_if.sink                       in_ch,
  lswg_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [lswg_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [lswg_pkg::ColorW-1:0]   cfg_data
);

  lswg_pkg::colors_t colors;
  lswg_pkg::entry_t  push_entry;
  lswg_pkg::entry_t  q_head;
  logic              push;
  logic              q_full;
  logic              q_pop;
  logic              q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      colors.text <= lswg_pkg::TextColorRst;
      colors.back <= lswg_pkg::BackColorRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lswg_pkg::CfgTextColor: colors.text <= cfg_data;
        lswg_pkg::CfgBackColor: colors.back <= cfg_data;
        default: ;
      endcase
    end
  end

  lswg_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lswg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  lswg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .colors      (colors),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

// File: hdl/lswg_chk.sv
// Port-level checker for the serial LCD writer, bound to the top level.
// Depends on lcd_serial_window_glyph_writer_unit ports only.
`default_nettype none

module lswg_chk (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] serial_word,
  input logic       select_release,
  input logic       last_word
);

  // a pending transaction stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped before transaction");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({serial_word, select_release, last_word}))
    else $error("out payload changed while stalled");

  // chip select always rises after the final word of an item
  a_last_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_word |-> select_release)
    else $error("last word without select release");

  // command words stand alone between chip-select edges
  a_cmd_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && !serial_word[8] |-> select_release)
    else $error("command word without select release");

endmodule

bind lcd_serial_window_glyph_writer_unit lswg_chk u_lswg_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .serial_word    (out_ch.serial_word),
  .select_release (out_ch.select_release),
  .last_word      (out_ch.last_word)
);

`default_nettype wire

// File: sim/testbench.sv
// Testbench for the 9-bit serial LCD window/glyph writer: drives drawing items and
// color writes, predicts the serial word stream and checks every outgoing word.
// Depends on lswg_pkg, lswg_if and lcd_serial_window_glyph_writer_unit.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 40;
  localparam int HoldCycles  = 300;

  // Register index that selects nothing
  localparam logic [lswg_pkg::CfgIndexW-1:0] CfgUnknown = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] win_width;
    logic [15:0] win_height;
    logic [15:0] pixel_value;
    logic [15:0] glyph_bits;
    logic [7:0]  byte_value;
  } draw_item_t;

  typedef struct packed {
    logic [8:0] word;
    logic       cs_release;
    logic       last;
  } lcd_word_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [lswg_pkg::CfgIndexW-1:0] cfg_index;
  logic [lswg_pkg::ColorW-1:0] cfg_data;

  lswg_in_if  in_ch();
  lswg_out_if out_ch();

  lcd_serial_window_glyph_writer_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Local copy of the color registers and the words still to come out
  logic [15:0] text_color_q;
  logic [15:0] back_color_q;
  lcd_word_t   expected_words[$];

  int errors = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  lcd_word_t want_w;
  lcd_word_t got_w;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("lcd_serial_window_glyph_writer_unit verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Outputs sampled mid-cycle; the transaction completes at the next rising edge
  always @(negedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      got_w.word = out_ch.serial_word;
      got_w.cs_release = out_ch.select_release;
      got_w.last = out_ch.last_word;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h rel %b last %b",
                 $time, got_w.word, got_w.cs_release, got_w.last);
      end else begin
        want_w = expected_words.pop_front();
        if (got_w.word !== want_w.word) begin
          errors++;
          $display("%0t: serial_word expected %h actual %h", $time, want_w.word, got_w.word);
        end
        if (got_w.cs_release !== want_w.cs_release) begin
          errors++;
          $display("%0t: select_release expected %b actual %b", $time, want_w.cs_release,
                   got_w.cs_release);
        end
        if (got_w.last !== want_w.last) begin
          errors++;
          $display("%0t: last_word expected %b actual %b", $time, want_w.last, got_w.last);
        end
      end
    end
  end

  function automatic void push_word(input logic rs, input logic [7:0] b, input logic rel);
    lcd_word_t w;
    w.word = {rs, b};
    w.cs_release = rel;
    w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  function automatic void push_coords(input logic [7:0] cmd, input logic [15:0] start,
                                      input logic [15:0] size);
    logic [15:0] stop;
    stop = start + size - 16'd1;
    push_word(lswg_pkg::RsCommand, cmd, 1'b1);
    push_word(lswg_pkg::RsData, start[15:8], 1'b1);
    push_word(lswg_pkg::RsData, start[7:0], 1'b1);
    push_word(lswg_pkg::RsData, stop[15:8], 1'b1);
    push_word(lswg_pkg::RsData, stop[7:0], 1'b1);
  endfunction

  function automatic void push_pixel(input logic [15:0] pix);
    push_word(lswg_pkg::RsData, pix[15:8], 1'b0);
    push_word(lswg_pkg::RsData, pix[7:0], 1'b1);
  endfunction

  // Expected word stream for one accepted drawing item
  function automatic void frame_item(input draw_item_t it);
    int first;
    lcd_word_t w;
    first = expected_words.size();
    case (it.action)
      lswg_pkg::ActSetWindow: begin
        push_coords(lswg_pkg::CmdColumnAddr, it.x_start, it.win_width);
        push_coords(lswg_pkg::CmdRowAddr, it.y_start, it.win_height);
        push_word(lswg_pkg::RsCommand, lswg_pkg::CmdMemWrite, 1'b1);
      end
      lswg_pkg::ActPixel: push_pixel(it.pixel_value);
      lswg_pkg::ActGlyphRow: begin
        for (int i = 0; i < 16; i++)
          push_pixel(it.glyph_bits[i] ? text_color_q : back_color_q);
      end
      lswg_pkg::ActRawCmd:  push_word(lswg_pkg::RsCommand, it.byte_value, 1'b1);
      lswg_pkg::ActRawData: push_word(lswg_pkg::RsData, it.byte_value, 1'b1);
      default: ;
    endcase
    if (expected_words.size() > first) begin
      w = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
    end
  endfunction

  function automatic draw_item_t random_item(input logic [2:0] act);
    draw_item_t it;
    it.action      = act;
    it.x_start     = 16'($urandom);
    it.y_start     = 16'($urandom);
    it.win_width   = 16'($urandom);
    it.win_height  = 16'($urandom);
    it.pixel_value = 16'($urandom);
    it.glyph_bits  = 16'($urandom);
    it.byte_value  = 8'($urandom);
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the item was taken
  task automatic send_item(input draw_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= it.action;
    in_ch.x_start     <= it.x_start;
    in_ch.y_start     <= it.y_start;
    in_ch.win_width   <= it.win_width;
    in_ch.win_height  <= it.win_height;
    in_ch.pixel_value <= it.pixel_value;
    in_ch.glyph_bits  <= it.glyph_bits;
    in_ch.byte_value  <= it.byte_value;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    frame_item(it);
  endtask

  task automatic send_window(input logic [15:0] x, y, w, h);
    draw_item_t it;
    it = random_item(lswg_pkg::ActSetWindow);
    it.x_start = x;
    it.y_start = y;
    it.win_width = w;
    it.win_height = h;
    send_item(it);
  endtask

  task automatic send_pixel(input logic [15:0] pix);
    draw_item_t it;
    it = random_item(lswg_pkg::ActPixel);
    it.pixel_value = pix;
    send_item(it);
  endtask

  task automatic send_glyph(input logic [15:0] bits);
    draw_item_t it;
    it = random_item(lswg_pkg::ActGlyphRow);
    it.glyph_bits = bits;
    send_item(it);
  endtask

  task automatic send_byte(input logic [2:0] act, input logic [7:0] b);
    draw_item_t it;
    it = random_item(act);
    it.byte_value = b;
    send_item(it);
  endtask

  // Sender pauses until every expected word is out, then lets the block settle
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Only while idle: both color registers, back to back
  task automatic write_colors(input logic [15:0] text, input logic [15:0] back);
    cfg_we    <= 1'b1;
    cfg_index <= lswg_pkg::CfgTextColor;
    cfg_data  <= text;
    @(posedge clk);
    cfg_index <= lswg_pkg::CfgBackColor;
    cfg_data  <= back;
    @(posedge clk);
    cfg_we <= 1'b0;
    text_color_q = text;
    back_color_q = back;
  endtask

  // Only while idle: a write to an index with no register changes nothing
  task automatic write_unknown_reg(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= CfgUnknown;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    write_unknown_reg(16'h1234);
    // zero size wraps the end coordinate to 0xFFFF
    send_window(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_window(16'h1234, 16'hFFFF, 16'h0001, 16'h0002);
    send_window(16'h00F0, 16'h0100, 16'h0140, 16'h00F0);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hA55A);
    // glyphs with the colors left by reset
    send_glyph(16'h0000);
    send_glyph(16'hFFFF);
    send_glyph(16'h8001);
    send_glyph(16'h5555);
    send_byte(lswg_pkg::ActRawCmd, 8'h00);
    send_byte(lswg_pkg::ActRawCmd, 8'hFF);
    send_byte(lswg_pkg::ActRawData, 8'h00);
    send_byte(lswg_pkg::ActRawData, 8'hFF);
    // unused action codes produce no words
    send_byte(3'd5, 8'h5A);
    send_pixel(16'h1234);
    send_byte(3'd6, 8'hA5);
    send_byte(3'd7, 8'h3C);
    send_byte(lswg_pkg::ActRawData, 8'h81);
    wait_until_drained();
  endtask

  task automatic test_color_extremes();
    logic [15:0] texts[4];
    logic [15:0] backs[4];
    texts = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'($urandom)};
    backs = '{16'h0000, 16'hFFFF, 16'h0000, 16'($urandom)};
    src_idle_pct = 13;
    sink_stall_pct = 13;
    for (int k = 0; k < 4; k++) begin
      write_colors(texts[k], backs[k]);
      send_glyph(16'h00FF);
      send_glyph(16'($urandom));
      send_pixel(16'($urandom));
      wait_until_drained();
    end
  endtask

  task automatic test_random_phases();
    int src_pcts[4];
    int sink_pcts[4];
    int useful;
    logic [2:0] act;
    draw_item_t it;
    src_pcts = '{0, 82, 0, 13};
    sink_pcts = '{0, 0, 82, 13};
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_pcts[p];
      sink_stall_pct = sink_pcts[p];
      write_colors(16'($urandom), 16'($urandom));
      useful = 0;
      while (useful < 30) begin
        if ($urandom_range(19) == 0) act = 3'($urandom_range(7, 5));
        else act = 3'($urandom_range(4, 0));
        if (act <= lswg_pkg::ActRawData) useful++;
        it = random_item(act);
        send_item(it);
      end
      wait_until_drained();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering glyph rows and a window
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    write_colors(16'($urandom), 16'($urandom));
    @(negedge clk);
    hold_requests++;
    @(posedge clk);
    for (int k = 0; k < 8; k++)
      send_glyph(16'($urandom));
    send_window(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    wait_until_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = lswg_pkg::CfgTextColor;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = lswg_pkg::ActSetWindow;
    in_ch.x_start = '0;
    in_ch.y_start = '0;
    in_ch.win_width = '0;
    in_ch.win_height = '0;
    in_ch.pixel_value = '0;
    in_ch.glyph_bits = '0;
    in_ch.byte_value = '0;
    text_color_q = lswg_pkg::TextColorRst;
    back_color_q = lswg_pkg::BackColorRst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_color_extremes();
    test_random_phases();
    test_backpressure();

    if (errors == 0) begin
      $display("lcd_serial_window_glyph_writer_unit verification clean");
    end else begin
      $display("lcd_serial_window_glyph_writer_unit verification failed");
    end
    $finish;
  end

endmodule
